[rtl/core/sgwl_pkg.sv]
// ----------------------------------------------------------------------------
// sgwl_pkg: shared types and codes of the start-gap wear leveler
// Register indexes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package sgwl_pkg;

   localparam int unsigned CSR_IDX_BITS = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WEAR_LIMIT       = 3'd0,
      CSR_GAP_PERIOD       = 3'd1,
      CSR_GROUP_LINES      = 3'd2,
      CSR_GROUP_COUNT      = 3'd3,
      CSR_LAST_GROUP_LINES = 3'd4,
      CSR_FAIL_THRESHOLD   = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,     // sweep the wear store after reset
      ST_IDLE,
      ST_TOTAL,     // compare against configured line total
      ST_DIV,       // restoring divide line / group_lines, one bit a cycle
      ST_ROT,       // latch the group index and its size
      ST_GAP,       // offset + start modulo size, skip the gap, issue wear read
      ST_RDWAIT,
      ST_WEAR,      // increment and compare against limit
      ST_UPDATE,    // write back wear and group pointers
      ST_RESP
   } state_type;

   localparam int unsigned LINE_BITS      = 14;
   localparam int unsigned FAILED_BITS    = 16;
   localparam int unsigned THRESH_BITS    = 15;
   localparam int unsigned PERIOD_BITS    = 16;
   localparam int unsigned GEO_BITS       = 11;
   localparam int unsigned COUNT_BITS     = 5;
   localparam int unsigned OUT_GROUP_BITS = 4;
   localparam int unsigned OUT_PHYS_BITS  = 11;
   localparam int unsigned OUT_WEAR_BITS  = 32;

endpackage
`default_nettype wire

[rtl/core/sgwl_ram.sv]
// ----------------------------------------------------------------------------
// sgwl_ram: generic single-port-write, registered-read RAM
// One write port and one read port, read data registered and valid in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none
module sgwl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/core/start_gap_wear_leveler_unit.sv]
// ----------------------------------------------------------------------------
// start_gap_wear_leveler_unit: start-gap wear leveling for line writes
// Maps logical line writes to physical lines and tracks per-line wear.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one beat per logical line write, tdata = logical_line.
//  - rsp_ channel: one beat per request with the mapping, wear count and
//    flags; out-of-range addresses return a beat with out_of_range set and
//    change no state.
//  - csr_ channel: register writes by index, taken at any time; write them
//    only while no request is in flight. A geometry write reloads every
//    group's start, gap and period counter.
// Sequence: a range check, then a one-bit-a-cycle restoring divide over the
//  LINE_BITS (14) address bits that splits the address into group and offset,
//  then mapping, wear read, update and response. An out-of-range write skips
//  the divide and goes from the range check straight to the response.
// Requests: one at a time; the next request is taken only once the block is
//  back in idle and the response beat has been taken by the receiver.
// Reset: after reset the wear store is swept to zero, one entry a cycle,
//  all MAX_GROUPS*(MAX_GROUP_LINES+1) entries (16400 at defaults); req_tready
//  stays low during the sweep.
// Stall: the response register holds its beat until rsp_tready; no new
//  request is taken until it is gone.
// ----------------------------------------------------------------------------
`default_nettype none
module start_gap_wear_leveler_unit #(
   parameter int unsigned MAX_GROUPS      = 16,
   parameter int unsigned MAX_GROUP_LINES = 1024,
   parameter int unsigned WEAR_BITS       = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [13:0] logical_line
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] group_index, [14:4] physical_line, [46:15] wear_count,
   // [47] line_failed, [48] gap_moved, [64:49] failed_lines,
   // [65] threshold_reached, [66] out_of_range
   output      logic [71:0] rsp_tdata,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int unsigned GB    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int unsigned SB    = $clog2(MAX_GROUP_LINES + 1);
   localparam int unsigned ROWS  = MAX_GROUP_LINES + 1;
   localparam int unsigned DEPTH = MAX_GROUPS * ROWS;
   localparam int unsigned AB    = $clog2(DEPTH);
   localparam int unsigned LB    = sgwl_pkg::LINE_BITS;
   localparam int unsigned DCB   = $clog2(LB + 1);
   localparam int unsigned TB    = LB + 8;
   localparam int unsigned RST_LINES = (MAX_GROUP_LINES < 1024) ? MAX_GROUP_LINES : 1024;
   localparam logic [WEAR_BITS-1:0] WMAX = '1;

   // configuration registers
   logic [31:0] wear_limit_ff;
   logic [sgwl_pkg::PERIOD_BITS-1:0] gap_period_ff;
   logic [sgwl_pkg::GEO_BITS-1:0] group_lines_ff, last_lines_ff;
   logic [sgwl_pkg::COUNT_BITS-1:0] group_count_ff;
   logic [sgwl_pkg::THRESH_BITS-1:0] fail_thr_ff;
   logic reload;
   logic reload_ff;

   // per-group pointers
   logic [SB-1:0] start_ff [MAX_GROUPS];
   logic [SB-1:0] gap_ff [MAX_GROUPS];
   logic [sgwl_pkg::PERIOD_BITS-1:0] period_ff [MAX_GROUPS];
   logic [sgwl_pkg::FAILED_BITS-1:0] failed_ff;

   // effective geometry, saturated
   logic [SB-1:0] eff_lines, eff_last;
   logic [GB:0] eff_count;
   always_comb begin
      if (group_lines_ff == '0) eff_lines = SB'(1);
      else if (32'(group_lines_ff) > MAX_GROUP_LINES) eff_lines = SB'(MAX_GROUP_LINES);
      else eff_lines = SB'(group_lines_ff);
      if (last_lines_ff == '0) eff_last = SB'(1);
      else if (32'(last_lines_ff) > 32'(eff_lines)) eff_last = eff_lines;
      else eff_last = SB'(last_lines_ff);
      if (group_count_ff == '0) eff_count = (GB+1)'(1);
      else if (32'(group_count_ff) > MAX_GROUPS) eff_count = (GB+1)'(MAX_GROUPS);
      else eff_count = (GB+1)'(group_count_ff);
   end

   sgwl_pkg::state_type state_ff, state_in;

   logic [AB-1:0] clr_ff;
   logic [TB-1:0] total_ff;
   logic [LB-1:0] line_ff;
   logic [LB-1:0] quo_ff;
   logic [SB:0] rem_ff;
   logic [DCB-1:0] bit_ff;
   logic [GB-1:0] grp_ff;
   logic [SB-1:0] size_ff;
   logic [SB:0] phys_ff;
   logic [AB-1:0] addr_ff;
   logic [WEAR_BITS-1:0] wear_ff;
   logic fail_ff, moved_ff, oor_ff;
   logic [71:0] rsp_ff;
   logic rsp_valid_ff;

   logic [WEAR_BITS-1:0] rd_data;
   logic wr_en;
   logic [AB-1:0] wr_addr;
   logic [WEAR_BITS-1:0] wr_data;

   sgwl_ram #(.WIDTH(WEAR_BITS), .DEPTH(DEPTH)) u_wear (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == sgwl_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign reload = csr_valid && (csr_index == sgwl_pkg::CSR_GROUP_LINES ||
                   csr_index == sgwl_pkg::CSR_GROUP_COUNT ||
                   csr_index == sgwl_pkg::CSR_LAST_GROUP_LINES);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sgwl_pkg::ST_CLEAR:  if (clr_ff == AB'(DEPTH - 1)) state_in = sgwl_pkg::ST_IDLE;
         sgwl_pkg::ST_IDLE:   if (req_tvalid && req_tready) state_in = sgwl_pkg::ST_TOTAL;
         sgwl_pkg::ST_TOTAL:
            if (TB'(line_ff) >= total_ff) state_in = sgwl_pkg::ST_RESP;
            else state_in = sgwl_pkg::ST_DIV;
         sgwl_pkg::ST_DIV:    if (bit_ff == '0) state_in = sgwl_pkg::ST_ROT;
         sgwl_pkg::ST_ROT:    state_in = sgwl_pkg::ST_GAP;
         sgwl_pkg::ST_GAP:    state_in = sgwl_pkg::ST_RDWAIT;
         sgwl_pkg::ST_RDWAIT: state_in = sgwl_pkg::ST_WEAR;
         sgwl_pkg::ST_WEAR:   state_in = sgwl_pkg::ST_UPDATE;
         sgwl_pkg::ST_UPDATE: state_in = sgwl_pkg::ST_RESP;
         sgwl_pkg::ST_RESP:   state_in = sgwl_pkg::ST_IDLE;
         default:             state_in = sgwl_pkg::ST_IDLE;
      endcase
   end

   // wear store write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = wear_ff;
      case (state_ff)
         sgwl_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         sgwl_pkg::ST_UPDATE: wr_en = 1'b1;
         default: wr_en = 1'b0;
      endcase
   end

   logic [SB:0] rem_sh;
   logic [SB:0] sum_rot;
   logic [WEAR_BITS-1:0] winc;
   logic [sgwl_pkg::PERIOD_BITS:0] cnt_next, per_eff;
   always_comb begin
      rem_sh   = {rem_ff[SB-1:0], line_ff[LB-1]};
      sum_rot  = rem_ff + (SB+1)'(start_ff[grp_ff]);
      winc     = (rd_data < WMAX) ? rd_data + 1'b1 : rd_data;
      cnt_next = (sgwl_pkg::PERIOD_BITS+1)'(period_ff[grp_ff]) + 1'b1;
      per_eff  = (gap_period_ff == '0) ? {1'b1, {sgwl_pkg::PERIOD_BITS{1'b0}}}
                                        : {1'b0, gap_period_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sgwl_pkg::ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         failed_ff      <= '0;
         wear_limit_ff  <= 32'd1000000;
         gap_period_ff  <= 16'd100;
         group_lines_ff <= 11'd1024;
         group_count_ff <= 5'd16;
         last_lines_ff  <= 11'd1024;
         fail_thr_ff    <= 15'd163;
         for (int g = 0; g < MAX_GROUPS; g++) begin
            start_ff[g]  <= '0;
            gap_ff[g]    <= SB'(RST_LINES);
            period_ff[g] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               sgwl_pkg::CSR_WEAR_LIMIT:       wear_limit_ff  <= csr_data;
               sgwl_pkg::CSR_GAP_PERIOD:       gap_period_ff  <= csr_data[15:0];
               sgwl_pkg::CSR_GROUP_LINES:      group_lines_ff <= csr_data[10:0];
               sgwl_pkg::CSR_GROUP_COUNT:      group_count_ff <= csr_data[4:0];
               sgwl_pkg::CSR_LAST_GROUP_LINES: last_lines_ff  <= csr_data[10:0];
               sgwl_pkg::CSR_FAIL_THRESHOLD:   fail_thr_ff    <= csr_data[14:0];
               default: ;
            endcase
         end
         case (state_ff)
            sgwl_pkg::ST_CLEAR: clr_ff <= clr_ff + 1'b1;
            sgwl_pkg::ST_IDLE: begin
               line_ff  <= req_tdata[LB-1:0];
               total_ff <= TB'(eff_lines) * TB'(eff_count - 1'b1) + TB'(eff_last);
            end
            sgwl_pkg::ST_TOTAL: begin
               rem_ff <= '0;
               quo_ff <= '0;
               bit_ff <= DCB'(LB - 1);
               oor_ff <= 1'b0;
               fail_ff <= 1'b0;
               moved_ff <= 1'b0;
               if (TB'(line_ff) >= total_ff) oor_ff <= 1'b1;
            end
            sgwl_pkg::ST_DIV: begin
               // restoring division, one quotient bit a cycle
               line_ff <= {line_ff[LB-2:0], 1'b0};
               bit_ff  <= bit_ff - 1'b1;
               if (rem_sh >= (SB+1)'(eff_lines)) begin
                  rem_ff <= rem_sh - (SB+1)'(eff_lines);
                  quo_ff <= {quo_ff[LB-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[LB-2:0], 1'b0};
               end
            end
            sgwl_pkg::ST_ROT: begin
               grp_ff  <= GB'(quo_ff);
               size_ff <= (quo_ff == LB'(eff_count - 1'b1)) ? eff_last : eff_lines;
            end
            sgwl_pkg::ST_GAP: begin
               // offset + start stays below twice the size: one subtract
               logic [SB:0] p;
               p = (sum_rot >= (SB+1)'(size_ff)) ? sum_rot - (SB+1)'(size_ff) : sum_rot;
               if (p >= (SB+1)'(gap_ff[grp_ff])) p = p + 1'b1;
               phys_ff <= p;
               addr_ff <= AB'(32'(grp_ff) * ROWS + 32'(p));
            end
            sgwl_pkg::ST_WEAR: begin
               if (64'(winc) >= 64'(wear_limit_ff)) begin
                  fail_ff <= 1'b1;
                  wear_ff <= '0;
                  if (failed_ff != '1) failed_ff <= failed_ff + 1'b1;
               end else begin
                  wear_ff <= winc;
               end
            end
            sgwl_pkg::ST_UPDATE: begin
               if (cnt_next >= per_eff) begin
                  moved_ff <= 1'b1;
                  period_ff[grp_ff] <= '0;
                  if (gap_ff[grp_ff] == SB'(1)) begin
                     gap_ff[grp_ff] <= size_ff;
                     start_ff[grp_ff] <= (start_ff[grp_ff] + 1'b1 >= size_ff) ? '0
                                          : start_ff[grp_ff] + 1'b1;
                  end else begin
                     gap_ff[grp_ff] <= gap_ff[grp_ff] - 1'b1;
                  end
               end else begin
                  period_ff[grp_ff] <= cnt_next[sgwl_pkg::PERIOD_BITS-1:0];
               end
            end
            sgwl_pkg::ST_RESP: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff <= '0;
               rsp_ff[64:49] <= failed_ff;
               rsp_ff[65] <= (32'(failed_ff) >= 32'(fail_thr_ff));
               rsp_ff[66] <= oor_ff;
               if (!oor_ff) begin
                  rsp_ff[3:0]   <= 4'(grp_ff);
                  rsp_ff[14:4]  <= 11'(phys_ff);
                  rsp_ff[46:15] <= 32'(wear_ff);
                  rsp_ff[47]    <= fail_ff;
                  rsp_ff[48]    <= moved_ff;
               end
            end
            default: ;
         endcase
         // geometry write: reload all pointers from the new values next cycle
         if (reload_ff) begin
            for (int g = 0; g < MAX_GROUPS; g++) begin
               start_ff[g]  <= '0;
               period_ff[g] <= '0;
               gap_ff[g]    <= (g == 32'(eff_count) - 1) ? eff_last : eff_lines;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) reload_ff <= 1'b0;
      else reload_ff <= reload;
   end
endmodule
`default_nettype wire

[rtl/core/sgwl_checker.sv]
// ----------------------------------------------------------------------------
// sgwl_checker: port-level checks of the start-gap wear leveler
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
`default_nettype none
module sgwl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);
   // a stalled response beat holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // no request is taken while a response waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted with response pending");

   // an accepted request is not answered in the next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("response too early");

   // a dropped write reports no mapping
   a_oor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66] |-> rsp_tdata[48:0] == '0)
      else $error("out of range beat carries mapping");
endmodule

bind start_gap_wear_leveler_unit sgwl_checker u_sgwl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

[sim/start_gap_wear_leveler_unit_tb.sv]
// ----------------------------------------------------------------------------
// start_gap_wear_leveler_unit_tb: self-checking bench of the wear leveler
// Drives line writes and register writes, predicts every response beat with
// an in-bench start-gap model and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module start_gap_wear_leveler_unit_tb;

   localparam int unsigned NGRP   = 16;
   localparam int unsigned NLINES = 1024;
   localparam int unsigned WDEPTH = NGRP * (NLINES + 1);
   localparam longint unsigned CYCLE_LIMIT = 3_000_000;

   // one expected response beat
   typedef struct packed {
      logic        out_of_range;
      logic        threshold_reached;
      logic [15:0] failed_lines;
      logic        gap_moved;
      logic        line_failed;
      logic [31:0] wear_count;
      logic [10:0] physical_line;
      logic [3:0]  group_index;
   } mapping_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [13:0] logical_line
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [3:0] group_index, [14:4] physical_line, [46:15] wear_count,
   // [47] line_failed, [48] gap_moved, [64:49] failed_lines,
   // [65] threshold_reached, [66] out_of_range
   logic [71:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // shadow configuration and leveler state
   logic [31:0] wear_limit;
   logic [15:0] gap_period;
   logic [10:0] group_lines;
   logic [4:0]  group_count;
   logic [10:0] last_group_lines;
   logic [14:0] fail_threshold;
   logic [9:0]  start_ptr [NGRP];
   logic [10:0] gap_ptr   [NGRP];
   logic [15:0] period_cnt[NGRP];
   logic [31:0] line_wear [WDEPTH];
   logic [15:0] failed_total;

   mapping_type expected_maps[$];
   int  error_count = 0;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  rsp_hold = 1'b0;
   int  hold_cycles = 0;
   longint unsigned cycle_count = 0;

   start_gap_wear_leveler_unit DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("start_gap_wear_leveler_unit_tb: errors");
         $finish;
      end
   end

   function automatic int unsigned eff_lines();
      if (group_lines < 1) return 1;
      if (group_lines > NLINES) return NLINES;
      return group_lines;
   endfunction

   function automatic int unsigned eff_count();
      if (group_count < 1) return 1;
      if (group_count > NGRP) return NGRP;
      return group_count;
   endfunction

   function automatic int unsigned eff_last();
      int unsigned lim;
      lim = eff_lines();
      if (last_group_lines < 1) return 1;
      if (last_group_lines > lim) return lim;
      return last_group_lines;
   endfunction

   function automatic int unsigned lines_in_group(int unsigned g);
      return (g == eff_count() - 1) ? eff_last() : eff_lines();
   endfunction

   function automatic int unsigned line_total();
      return eff_lines() * (eff_count() - 1) + eff_last();
   endfunction

   function automatic void reload_groups();
      for (int g = 0; g < NGRP; g++) begin
         start_ptr[g]  = '0;
         gap_ptr[g]    = 11'(lines_in_group(g));
         period_cnt[g] = '0;
      end
   endfunction

   function automatic void shadow_reset();
      wear_limit       = 32'd1000000;
      gap_period       = 16'd100;
      group_lines      = 11'd1024;
      group_count      = 5'd16;
      last_group_lines = 11'd1024;
      fail_threshold   = 15'd163;
      foreach (line_wear[i]) line_wear[i] = '0;
      failed_total = '0;
      reload_groups();
   endfunction

   function automatic void shadow_csr(sgwl_pkg::csr_index_type idx, logic [31:0] v);
      case (idx)
         sgwl_pkg::CSR_WEAR_LIMIT:       wear_limit = v;
         sgwl_pkg::CSR_GAP_PERIOD:       gap_period = v[15:0];
         sgwl_pkg::CSR_GROUP_LINES: begin
            group_lines = v[10:0];
            reload_groups();
         end
         sgwl_pkg::CSR_GROUP_COUNT: begin
            group_count = v[4:0];
            reload_groups();
         end
         sgwl_pkg::CSR_LAST_GROUP_LINES: begin
            last_group_lines = v[10:0];
            reload_groups();
         end
         sgwl_pkg::CSR_FAIL_THRESHOLD:   fail_threshold = v[14:0];
         default: ;
      endcase
   endfunction

   // map one line write and update wear and pointers
   function automatic mapping_type map_line_write(logic [13:0] line);
      mapping_type m;
      int unsigned g, off, sz, p, cnt, per, slot;
      logic [31:0] w;
      m = '0;
      if (line >= line_total()) begin
         m.failed_lines      = failed_total;
         m.threshold_reached = (failed_total >= fail_threshold);
         m.out_of_range      = 1'b1;
         return m;
      end
      g   = line / eff_lines();
      off = line % eff_lines();
      sz  = lines_in_group(g);
      p   = (off + start_ptr[g]) % sz;
      if (p >= gap_ptr[g]) p++;
      slot = g * (NLINES + 1) + p;
      w = line_wear[slot];
      if (w != 32'hFFFF_FFFF) w++;
      if (w >= wear_limit) begin
         m.line_failed = 1'b1;
         w = '0;
         if (failed_total != 16'hFFFF) failed_total++;
      end
      line_wear[slot] = w;
      cnt = period_cnt[g] + 1;
      per = (gap_period != 0) ? gap_period : 65536;
      if (cnt >= per) begin
         cnt = 0;
         m.gap_moved = 1'b1;
         gap_ptr[g]--;
         if (gap_ptr[g] == 0) begin
            gap_ptr[g]   = 11'(sz);
            start_ptr[g] = 10'((start_ptr[g] + 1) % sz);
         end
      end
      period_cnt[g] = 16'(cnt);
      m.group_index       = 4'(g);
      m.physical_line     = 11'(p);
      m.wear_count        = w;
      m.failed_lines      = failed_total;
      m.threshold_reached = (failed_total >= fail_threshold);
      return m;
   endfunction

   // send one line write; predict at acceptance
   task automatic send_line(logic [13:0] line);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
         @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, line};
      do @(posedge clock); while (!req_tready);
      expected_maps.push_back(map_line_write(line));
      req_tvalid <= 1'b0;
      // drop valid for one cycle; the block is busy long after an accept
      @(posedge clock);
   endtask

   // wait for the block to drain, then write one register
   task automatic write_csr(sgwl_pkg::csr_index_type idx, logic [31:0] v);
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      shadow_csr(idx, v);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(int gl, int gc, int ll);
      write_csr(sgwl_pkg::CSR_GROUP_LINES, gl);
      write_csr(sgwl_pkg::CSR_GROUP_COUNT, gc);
      write_csr(sgwl_pkg::CSR_LAST_GROUP_LINES, ll);
   endtask

   // receiver: stall at random, or hold off entirely during pressure
   always @(posedge clock) begin
      if (rsp_hold)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // checker: compare each accepted beat with the oldest prediction
   always @(posedge clock) begin
      mapping_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mapping_type'(rsp_tdata[66:0]);
         if (expected_maps.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            error_count++;
         end else begin
            want = expected_maps.pop_front();
            if (got.group_index !== want.group_index ||
                got.physical_line !== want.physical_line ||
                got.wear_count !== want.wear_count ||
                got.line_failed !== want.line_failed ||
                got.gap_moved !== want.gap_moved ||
                got.failed_lines !== want.failed_lines ||
                got.threshold_reached !== want.threshold_reached ||
                got.out_of_range !== want.out_of_range) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, got);
               error_count++;
            end
         end
      end
   end

   // mostly in-range lines, a few beyond the configured total
   task automatic random_lines(int n, bit hot);
      int unsigned tot;
      logic [13:0] line;
      for (int i = 0; i < n; i++) begin
         tot = line_total();
         if ($urandom_range(9) == 0)
            line = 14'($urandom_range(16383));
         else if (hot)
            line = 14'($urandom_range(tot - 1 < 7 ? tot - 1 : 7));
         else
            line = 14'($urandom_range(tot - 1));
         send_line(line);
      end
   endtask

   task automatic test_directed();
      // defaults: field extremes; the top line 16383 is still in range
      send_line(14'd0);
      send_line(14'd16383);
      send_line(14'h2AAA);
      send_line(14'h1555);
      // tiny geometry, fast gap, low wear limit
      set_geometry(3, 2, 2);
      write_csr(sgwl_pkg::CSR_GAP_PERIOD, 1);
      write_csr(sgwl_pkg::CSR_WEAR_LIMIT, 2);
      write_csr(sgwl_pkg::CSR_FAIL_THRESHOLD, 2);
      for (int i = 0; i < 6; i++) send_line(14'(i));
      send_line(14'd3);
      send_line(14'd4);
      // wear limit zero: every write fails; gap period zero
      write_csr(sgwl_pkg::CSR_WEAR_LIMIT, 0);
      write_csr(sgwl_pkg::CSR_GAP_PERIOD, 0);
      send_line(14'd1);
      send_line(14'd4);
      // lowered period: counter already above new period
      write_csr(sgwl_pkg::CSR_GAP_PERIOD, 5);
      for (int i = 0; i < 3; i++) send_line(14'd0);
      write_csr(sgwl_pkg::CSR_GAP_PERIOD, 2);
      send_line(14'd0);
      // geometry saturation: zero and oversize values
      set_geometry(0, 0, 0);
      send_line(14'd0);
      send_line(14'd1);
      set_geometry(2047, 31, 2047);
      send_line(14'd16383);
      send_line(14'd15360);
      write_csr(sgwl_pkg::CSR_FAIL_THRESHOLD, 32'h7FFF);
      write_csr(sgwl_pkg::CSR_WEAR_LIMIT, 32'hFFFF_FFFF);
      send_line(14'd5);
   endtask

   task automatic test_random_settings();
      // phase: no idling, small groups, period 1
      set_geometry(4, 3, 1);
      write_csr(sgwl_pkg::CSR_GAP_PERIOD, 1);
      write_csr(sgwl_pkg::CSR_WEAR_LIMIT, 3);
      write_csr(sgwl_pkg::CSR_FAIL_THRESHOLD, 20);
      send_idle_pct = 0; rsp_stall_pct = 0;
      random_lines(200, 1);
      // phase: sender idle most of the time
      set_geometry(1024, 1, 1024);
      write_csr(sgwl_pkg::CSR_GAP_PERIOD, 3);
      write_csr(sgwl_pkg::CSR_WEAR_LIMIT, 1_000_000);
      send_idle_pct = 82; rsp_stall_pct = 0;
      random_lines(150, 0);
      // phase: receiver stalling most of the time
      set_geometry(7, 16, 5);
      write_csr(sgwl_pkg::CSR_GAP_PERIOD, 2);
      write_csr(sgwl_pkg::CSR_WEAR_LIMIT, 4);
      write_csr(sgwl_pkg::CSR_FAIL_THRESHOLD, 0);
      send_idle_pct = 0; rsp_stall_pct = 82;
      random_lines(200, 0);
      // phase: both idle and stall
      set_geometry(2, 5, 2);
      write_csr(sgwl_pkg::CSR_GAP_PERIOD, 65535);
      write_csr(sgwl_pkg::CSR_WEAR_LIMIT, 1);
      write_csr(sgwl_pkg::CSR_FAIL_THRESHOLD, 16384);
      send_idle_pct = 21; rsp_stall_pct = 21;
      random_lines(200, 1);
      // phase: default geometry, random gap period, no idling or stalls
      set_geometry(1024, 16, 1024);
      write_csr(sgwl_pkg::CSR_GAP_PERIOD, $urandom_range(1, 4));
      write_csr(sgwl_pkg::CSR_WEAR_LIMIT, 2);
      send_idle_pct = 0; rsp_stall_pct = 0;
      random_lines(150, 1);
   endtask

   // hold the receiver off for a long stretch while requests keep coming
   task automatic test_backpressure();
      send_idle_pct = 0; rsp_stall_pct = 0;
      fork
         begin
            rsp_hold = 1'b1;
            hold_cycles = 0;
            while (hold_cycles < 400) begin
               @(posedge clock);
               hold_cycles++;
            end
            rsp_hold = 1'b0;
         end
         random_lines(25, 1);
      join
   endtask

   initial begin
      shadow_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_settings();
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_maps.size() == 0)
         $display("start_gap_wear_leveler_unit_tb: clean");
      else
         $display("start_gap_wear_leveler_unit_tb: errors");
      $finish;
   end

endmodule
`default_nettype wire
